// File: sv/chx_pkg.sv
// ----------------------------------------------------------------------------
// chx_pkg: shared types and constants for the compass heading extrapolator
// Angle widths, CORDIC sizing and the arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chx_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = (CORDIC_RUN > 1) ? $clog2(CORDIC_RUN) : 1;

    localparam int MAG_W  = 16;
    localparam int BIAS_W = 18;
    localparam int ANG_W  = 24;
    localparam int XY_W   = 28;
    localparam int Z_W    = 25;
    localparam int TAB_W  = 22;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [Z_W-1:0]   zang_t;

    localparam zang_t Z_QUARTER = zang_t'(90 * 65536);

    function automatic logic [TAB_W-1:0] atan_entry(input logic [4:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/compass_heading_extrapolator.sv
// ----------------------------------------------------------------------------
// compass_heading_extrapolator: magnetometer heading with extrapolation
// atan2 heading by iterative CORDIC plus bias, or linear extrapolation.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    data_ready, mag_x, mag_y
//   out      output     out_valid / out_ready  heading
//   cfg      input      cfg_wr_en              bias_angle
//
// A sample item runs CORDIC_RUN steps (16 here) on the single CORDIC
// shift/add unit, one step per cycle. An all-zero sample and an
// extrapolation item skip the CORDIC. in_ready is low while an item is at work.
// A stalled output holds the finished item and the next item may still be
// accepted; a further result waits until the output register frees.
// Reset clears the heading history, the bias and all control state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_extrapolator (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire                                    data_ready,
    input  wire logic signed [chx_pkg::MAG_W-1:0]  mag_x,
    input  wire logic signed [chx_pkg::MAG_W-1:0]  mag_y,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output chx_pkg::angle_t                        heading,
    input  wire                                    cfg_wr_en,
    input  wire logic signed [chx_pkg::BIAS_W-1:0] bias_angle
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    localparam int SUM_W = chx_pkg::ANG_W + 2;

    logic                              state_reg, state_next;
    logic                              sample_reg, sample_next;
    logic                              out_valid_reg, out_valid_next;
    chx_pkg::angle_t                   heading_reg, heading_next;
    logic signed [chx_pkg::BIAS_W-1:0] bias_reg;
    chx_pkg::angle_t                   cur_reg, cur_next;
    chx_pkg::angle_t                   prev_reg, prev_next;
    chx_pkg::angle_t                   old_reg, old_next;

    logic                              accept, start, emit;
    logic                              cordic_busy;
    chx_pkg::zang_t                    cordic_angle;
    logic signed [chx_pkg::Z_W:0]      z_rnd;
    logic signed [chx_pkg::BIAS_W:0]   meas;
    chx_pkg::angle_t                   meas_h;
    logic signed [SUM_W-1:0]           ext_sum;
    chx_pkg::angle_t                   ext_h;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign start    = accept && data_ready;
    assign emit     = (state_reg == ST_WORK) && !cordic_busy
                      && (!out_valid_reg || out_ready);

    chx_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mag_x (mag_x),
        .mag_y (mag_y),
        .busy  (cordic_busy),
        .angle (cordic_angle)
    );

    assign z_rnd  = {cordic_angle[chx_pkg::Z_W-1], cordic_angle} + (chx_pkg::Z_W+1)'(128);
    assign meas   = {z_rnd[chx_pkg::Z_W], z_rnd[chx_pkg::Z_W:8]}
                    + {bias_reg[chx_pkg::BIAS_W-1], bias_reg};
    assign meas_h = chx_pkg::angle_t'(meas);

    assign ext_sum = SUM_W'(cur_reg) + SUM_W'(prev_reg) - SUM_W'(old_reg);

    always_comb
    begin
        if (ext_sum > SUM_W'(8388607))
        begin
            ext_h = chx_pkg::angle_t'(8388607);
        end
        else if (ext_sum < -SUM_W'(8388608))
        begin
            ext_h = chx_pkg::angle_t'(-8388608);
        end
        else
        begin
            ext_h = ext_sum[chx_pkg::ANG_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        heading_next   = heading_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        old_next       = old_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = data_ready;
                    state_next  = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    old_next       = prev_reg;
                    state_next     = ST_IDLE;
                    if (sample_reg)
                    begin
                        heading_next = meas_h;
                        prev_next    = cur_reg;
                        cur_next     = meas_h;
                    end
                    else
                    begin
                        heading_next = ext_h;
                        prev_next    = ext_h;
                        cur_next     = ext_h;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sample_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            bias_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            old_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sample_reg    <= sample_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            old_reg       <= old_next;
            if (cfg_wr_en)
            begin
                bias_reg <= bias_angle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

    a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_busy |-> state_reg == ST_WORK)
        else $error("CORDIC running outside an item");

    a_accept_block: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("item accepted while another is at work");

    a_emit_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(state_reg == ST_WORK))
        else $error("result raised without an item at work");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> old_reg == $past(prev_reg) && cur_reg == heading_reg)
        else $error("heading history shifted wrongly");

endmodule

`default_nettype wire

// File: sv/chx_cordic.sv
// ----------------------------------------------------------------------------
// chx_cordic: iterative vectoring CORDIC
// One add/subtract and shift step per cycle; angle in 1/65536 degree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chx_cordic (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire logic signed [chx_pkg::MAG_W-1:0] mag_x,
    input  wire logic signed [chx_pkg::MAG_W-1:0] mag_y,
    output logic                             busy,
    output chx_pkg::zang_t                   angle
);

    localparam int XY_W = chx_pkg::XY_W;

    logic                         busy_reg, busy_next;
    logic [chx_pkg::STEP_W-1:0]   step_reg, step_next;
    logic signed [XY_W-1:0]       x_reg, x_next;
    logic signed [XY_W-1:0]       y_reg, y_next;
    chx_pkg::zang_t               z_reg, z_next;

    logic signed [XY_W-1:0]       x0, y0, dx, dy;
    chx_pkg::zang_t               t_ext;

    assign x0 = {{(XY_W-chx_pkg::MAG_W-8){mag_x[chx_pkg::MAG_W-1]}}, mag_x, 8'b0};
    assign y0 = {{(XY_W-chx_pkg::MAG_W-8){mag_y[chx_pkg::MAG_W-1]}}, mag_y, 8'b0};
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign t_ext = chx_pkg::zang_t'({3'b000, chx_pkg::atan_entry(5'(step_reg))});

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            step_next = '0;
            if (mag_x == '0 && mag_y == '0)
            begin
                busy_next = 1'b0;
                x_next    = x0;
                y_next    = y0;
                z_next    = '0;
            end
            else
            begin
                busy_next = 1'b1;
                if (x0 < 0)
                begin
                    if (y0 >= 0)
                    begin
                        x_next = y0;
                        y_next = -x0;
                        z_next = chx_pkg::Z_QUARTER;
                    end
                    else
                    begin
                        x_next = -y0;
                        y_next = x0;
                        z_next = -chx_pkg::Z_QUARTER;
                    end
                end
                else
                begin
                    x_next = x0;
                    y_next = y0;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + t_ext;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - t_ext;
            end
            // advance, drop busy after the last step
            if (step_reg == chx_pkg::STEP_W'(chx_pkg::CORDIC_RUN - 1))
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy  = busy_reg;
    assign angle = z_reg;

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> step_reg == '0 || $past(busy_reg))
        else $error("step counter moved while idle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && step_reg != chx_pkg::STEP_W'(chx_pkg::CORDIC_RUN - 1))
            |=> busy_reg)
        else $error("iteration stopped early");

    a_step_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && step_reg != chx_pkg::STEP_W'(chx_pkg::CORDIC_RUN - 1))
            |=> step_reg == $past(step_reg) + 1'b1)
        else $error("step counter did not advance");

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: compass heading extrapolator
// Drives magnetometer samples and extrapolation items through the valid/ready input
// and compares every heading against an in-bench CORDIC predictor that keeps its
// own heading history and bias, or a probe's typed heading. A short table of
// directed items comes first. Random phases follow, one per bias setting, with
// ramps driven into saturation, random idling on both sides, long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int  BIAS_LIMIT     = 92160;
    localparam int  PHASE_COUNT    = 6;
    localparam int  PHASE_ITEMS    = 325;
    localparam int  RAMP_LEN       = 100;
    localparam int  SETTLE_CYCLES  = 20;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  MAX_REPORTS    = 10;
    localparam int  PROBE_COUNT    = 24;
    localparam longint HDG_HI      = 64'sd8388607;
    localparam longint HDG_LO      = -64'sd8388608;

    localparam logic MODE_SAMPLE = 1'b1;
    localparam logic MODE_EXTRAP = 1'b0;

    typedef logic signed [chx_pkg::MAG_W-1:0]  mag_t;
    typedef logic signed [chx_pkg::BIAS_W-1:0] bias_t;

    typedef struct packed {
        logic                             mode;
        logic signed [chx_pkg::MAG_W-1:0] x;
        logic signed [chx_pkg::MAG_W-1:0] y;
        logic                             typed;
        chx_pkg::angle_t                  hdg;
    } probe_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic                              data_ready;
    logic signed [chx_pkg::MAG_W-1:0]  mag_x;
    logic signed [chx_pkg::MAG_W-1:0]  mag_y;
    logic                              out_valid;
    logic                              out_ready;
    chx_pkg::angle_t                   heading;
    logic                              cfg_wr_en;
    logic signed [chx_pkg::BIAS_W-1:0] bias_angle;

    probe_t          probes [0:PROBE_COUNT-1];
    chx_pkg::angle_t heading_fifo [$];

    longint hdg_now;
    longint hdg_prev;
    longint hdg_old;
    longint bias_now;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int results_seen;
    int next_hold;
    int hold_left;
    int mismatches;
    int quiet_cycles;

    compass_heading_extrapolator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_ready (data_ready),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .heading    (heading),
        .cfg_wr_en  (cfg_wr_en),
        .bias_angle (bias_angle)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint atan_step(input int i);
        longint v;
        case (i)
            0:       v = 2949120;
            1:       v = 1740967;
            2:       v = 919879;
            3:       v = 466945;
            4:       v = 234379;
            5:       v = 117304;
            6:       v = 58666;
            7:       v = 29335;
            8:       v = 14668;
            9:       v = 7334;
            10:      v = 3667;
            11:      v = 1833;
            12:      v = 917;
            13:      v = 458;
            14:      v = 229;
            15:      v = 115;
            16:      v = 57;
            17:      v = 29;
            18:      v = 14;
            19:      v = 7;
            20:      v = 4;
            21:      v = 2;
            22:      v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

    function automatic longint clamp_heading(input longint v);
        if (v > HDG_HI)
            return HDG_HI;
        if (v < HDG_LO)
            return HDG_LO;
        return v;
    endfunction

    // vectoring CORDIC, angle in 1/65536 degree, result in 1/256 degree
    function automatic longint cordic_deg256(input longint xs, input longint ys);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        int     i;
        x = xs * 256;
        y = ys * 256;
        z = 0;
        if (xs == 0 && ys == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 90 * 65536;
            end
            else
            begin
                x = -y;
                y = t;
                z = -90 * 65536;
            end
        end
        for (i = 0; i < chx_pkg::CORDIC_STEPS && i < chx_pkg::TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic chx_pkg::angle_t next_heading(input logic mode,
                                                     input mag_t x,
                                                     input mag_t y);
        longint h;
        if (mode == MODE_SAMPLE)
        begin
            h = clamp_heading(cordic_deg256(longint'(x), longint'(y)) + bias_now);
            hdg_old  = hdg_prev;
            hdg_prev = hdg_now;
            hdg_now  = h;
        end
        else
        begin
            h = clamp_heading(hdg_now + (hdg_prev - hdg_old));
            hdg_old  = hdg_prev;
            hdg_prev = h;
            hdg_now  = h;
        end
        return chx_pkg::angle_t'(h);
    endfunction

    // called just after a rising edge; returns on the edge that takes the item
    task automatic send_item(input logic mode,
                             input mag_t x,
                             input mag_t y,
                             input logic typed,
                             input chx_pkg::angle_t typed_hdg);
        logic            taken;
        chx_pkg::angle_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_ready <= mode;
        mag_x      <= x;
        mag_y      <= y;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        predicted = next_heading(mode, x, y);
        heading_fifo.push_back(typed ? typed_hdg : predicted);
        items_sent++;
    endtask

    task automatic pick_vector(output mag_t x,
                               output mag_t y);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            x = mag_t'($urandom);
            y = mag_t'($urandom);
        end
        else if (kind <= 7)
        begin
            x = mag_t'(int'($urandom_range(0, 8)) - 4);
            y = mag_t'(int'($urandom_range(0, 8)) - 4);
        end
        else if (kind == 8)
        begin
            x = '0;
            y = '0;
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            x = mag_t'($urandom);
            y = '0;
        end
        else
        begin
            x = '0;
            y = mag_t'($urandom);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (heading_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bias(input int value);
        cfg_wr_en  <= 1'b1;
        bias_angle <= bias_t'(value);
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        bias_now = value;
        @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int   start;
        int   kind;
        int   k;
        int   run_len;
        mag_t x;
        mag_t y;
        mag_t y_from;
        mag_t y_to;
        start = items_sent;
        // ramp from one side of the negative x axis to the other, into saturation
        if ($urandom_range(0, 1) == 1)
        begin
            y_from = 16'hFFFF;
            y_to   = 16'h0000;
        end
        else
        begin
            y_from = 16'h0000;
            y_to   = 16'hFFFF;
        end
        send_item(MODE_SAMPLE, 16'h8000, y_from, 1'b0, '0);
        send_item(MODE_SAMPLE, 16'h8000, y_from, 1'b0, '0);
        send_item(MODE_SAMPLE, 16'h8000, y_to, 1'b0, '0);
        for (k = 0; k < RAMP_LEN; k++)
            send_item(MODE_EXTRAP, mag_t'($urandom), mag_t'($urandom), 1'b0, '0);
        while (items_sent - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                pick_vector(x, y);
                send_item(MODE_SAMPLE, x, y, 1'b0, '0);
                run_len = $urandom_range(0, 3);
                for (k = 0; k < run_len; k++)
                    send_item(MODE_EXTRAP, mag_t'($urandom), mag_t'($urandom), 1'b0, '0);
            end
            else if (kind < 85)
            begin
                run_len = $urandom_range(1, 8);
                for (k = 0; k < run_len; k++)
                    send_item(MODE_EXTRAP, mag_t'($urandom), mag_t'($urandom), 1'b0, '0);
            end
            else
            begin
                pick_vector(x, y);
                send_item(1'($urandom_range(0, 1)), x, y, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        int i;
        int ph;
        int bias_pick;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_ready <= 1'b0;
        mag_x      <= '0;
        mag_y      <= '0;
        cfg_wr_en  <= 1'b0;
        bias_angle <= '0;
        hdg_now  = 0;
        hdg_prev = 0;
        hdg_old  = 0;
        bias_now = 0;
        items_sent    = 0;
        send_idle_pct = 37;
        recv_idle_pct = 54;

        probes[0]  = '{MODE_EXTRAP, 16'h0000, 16'h0000, 1'b1, 24'sd0};
        probes[1]  = '{MODE_SAMPLE, 16'h0000, 16'h0000, 1'b1, 24'sd0};
        probes[2]  = '{MODE_EXTRAP, 16'hFFFF, 16'h8000, 1'b1, 24'sd0};
        probes[3]  = '{MODE_SAMPLE, 16'h7FFF, 16'h0000, 1'b0, 24'sd0};
        probes[4]  = '{MODE_SAMPLE, 16'h8000, 16'h0000, 1'b0, 24'sd0};
        probes[5]  = '{MODE_SAMPLE, 16'h8000, 16'hFFFF, 1'b0, 24'sd0};
        probes[6]  = '{MODE_SAMPLE, 16'h0000, 16'h7FFF, 1'b0, 24'sd0};
        probes[7]  = '{MODE_SAMPLE, 16'h0000, 16'h8000, 1'b0, 24'sd0};
        probes[8]  = '{MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b0, 24'sd0};
        probes[9]  = '{MODE_SAMPLE, 16'h8000, 16'h8000, 1'b0, 24'sd0};
        probes[10] = '{MODE_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, 24'sd0};
        probes[11] = '{MODE_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, 24'sd0};
        probes[12] = '{MODE_SAMPLE, 16'h0001, 16'h0001, 1'b0, 24'sd0};
        probes[13] = '{MODE_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, 24'sd0};
        probes[14] = '{MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, 24'sd0};
        probes[15] = '{MODE_SAMPLE, 16'h0001, 16'hFFFF, 1'b0, 24'sd0};
        probes[16] = '{MODE_EXTRAP, 16'h7FFF, 16'h7FFF, 1'b0, 24'sd0};
        probes[17] = '{MODE_EXTRAP, 16'h8000, 16'h0001, 1'b0, 24'sd0};
        probes[18] = '{MODE_SAMPLE, 16'h0000, 16'h0001, 1'b0, 24'sd0};
        probes[19] = '{MODE_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, 24'sd0};
        probes[20] = '{MODE_SAMPLE, 16'h0001, 16'h0000, 1'b0, 24'sd0};
        probes[21] = '{MODE_EXTRAP, 16'h0000, 16'h0000, 1'b0, 24'sd0};
        probes[22] = '{MODE_SAMPLE, 16'h0000, 16'h0000, 1'b1, 24'sd0};
        probes[23] = '{MODE_EXTRAP, 16'h5A5A, 16'hA5A5, 1'b0, 24'sd0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PROBE_COUNT; i++)
            send_item(probes[i].mode, probes[i].x, probes[i].y,
                      probes[i].typed, probes[i].hdg);

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 37;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:       bias_pick = BIAS_LIMIT;
                1:       bias_pick = -BIAS_LIMIT;
                3:       bias_pick = 0;
                default: bias_pick = int'($urandom_range(0, 2 * BIAS_LIMIT)) - BIAS_LIMIT;
            endcase
            drain_and_settle();
            write_bias(bias_pick);
            run_random(PHASE_ITEMS);
        end

        drain_and_settle();
        if (mismatches == 0 && heading_fifo.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // output side: random stalls, a long hold-off now and then, and the check
    initial
    begin
        chx_pkg::angle_t want;
        out_ready    <= 1'b0;
        results_seen = 0;
        next_hold    = 500;
        hold_left    = 0;
        mismatches   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                results_seen++;
                if (results_seen == next_hold)
                begin
                    hold_left = HOLD_CYCLES;
                    next_hold = (next_hold == 500) ? 1600 : -1;
                end
                if (heading_fifo.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected heading %0d with nothing outstanding", heading);
                end
                else
                begin
                    want = heading_fifo.pop_front();
                    if (heading !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("heading mismatch: expected %0d, got %0d", want, heading);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
